// ===== rtl/brcr_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// brcr_pkg
// Shared types and constants for the branch and condition register unit.
// ----------------------------------------------------------------------------
package brcr_pkg;

    localparam int WORD_W          = 32;
    localparam int CMD_W           = 4;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [WORD_W-1:0] TARGET_MASK     = 32'hffff_fffc;
    localparam logic [WORD_W-1:0] XER_NIBBLE_MASK = 32'hf000_0000;
    localparam int                XER_NIBBLE_LSB  = 28;

    typedef enum logic [CMD_W-1:0] {
        CMD_B        = 4'd0,
        CMD_BC       = 4'd1,
        CMD_BCLR     = 4'd2,
        CMD_BCCTR    = 4'd3,
        CMD_MCRF     = 4'd4,
        CMD_MFCR     = 4'd5,
        CMD_MTCRF    = 4'd6,
        CMD_MCRXR    = 4'd7,
        CMD_LOAD_CTR = 4'd8,
        CMD_LOAD_LR  = 4'd9,
        CMD_LOAD_XER = 4'd10
    } t_cmd;

    // Classified operation, as it travels from front to back
    typedef struct packed {
        t_cmd              cmd;
        logic [4:0]        bo;
        logic [4:0]        bi;
        logic              lk;
        logic [2:0]        crf_d;
        logic [2:0]        crf_s;
        logic [WORD_W-1:0] br_target;  // b / bc target, AA already applied
        logic [WORD_W-1:0] seq_addr;   // instruction address + 4
        logic [WORD_W-1:0] operand;    // register operand
        logic [WORD_W-1:0] crm_mask;   // mtcrf field mask, nibble expanded
    } t_op;

endpackage

`default_nettype wire

// ===== rtl/brcr_in_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// brcr_in_if
// Input channel: one instruction transaction with valid/ready handshake.
// ----------------------------------------------------------------------------
interface brcr_in_if;
    import brcr_pkg::*;

    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [WORD_W-1:0] instr_word;
    logic [WORD_W-1:0] instr_address;
    logic [WORD_W-1:0] reg_value;

    modport source (
        output valid, command, instr_word, instr_address, reg_value,
        input  ready
    );

    modport sink (
        input  valid, command, instr_word, instr_address, reg_value,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/brcr_out_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// brcr_out_if
// Result channel: one result transaction with valid/ready handshake.
// ----------------------------------------------------------------------------
interface brcr_out_if;
    import brcr_pkg::*;

    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] next_address;
    logic              taken;
    logic [WORD_W-1:0] reg_result;
    logic              reg_write;

    modport source (
        output valid, next_address, taken, reg_result, reg_write,
        input  ready
    );

    modport sink (
        input  valid, next_address, taken, reg_result, reg_write,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/branch_and_condition_register_unit.sv =====
`default_nettype none
// Path: an accepted transaction is first written into the queue; the back
//   then executes it from the queue into the output register.
// Throughput: one transaction per cycle while the result side keeps ready high.
// Reset: synchronous, active low; clears CR, CTR, LR, XER nibble, queue and
//   output valid. The block is ready in the first cycle after reset.
// ----------------------------------------------------------------------------
// branch_and_condition_register_unit
// Resolves b/bc/bclr/bcctr and executes the CR move instructions plus
// CTR/LR/XER loads. Front classifies, a short queue decouples, back executes.
// ----------------------------------------------------------------------------
module branch_and_condition_register_unit #(
    parameter int QUEUE_DEPTH = brcr_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    brcr_in_if.sink    i_in,
    brcr_out_if.source o_out
);
    import brcr_pkg::*;

    // Front to queue
    logic push_valid;
    logic push_ready;
    t_op  push_data;

    // Queue to back
    logic pop_valid;
    logic pop_ready;
    t_op  pop_data;

    // Front: decode fields, sign-extend displacement, form target and
    // fall-through addresses; none of this touches architectural state.
    brcr_front u_front (
        .i_in         (i_in),
        .i_push_ready (push_ready),
        .o_push_valid (push_valid),
        .o_push_data  (push_data)
    );

    // Queue: lets the front keep taking transactions while the result
    // register is stalled, and vice versa.
    brcr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_data  (push_data),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_data   (pop_data)
    );

    // Back: owns CR/CTR/LR/XER, executes in order, one op per cycle while the
    // result register is not stalled; results registered toward the sink.
    brcr_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op_valid (pop_valid),
        .o_op_ready (pop_ready),
        .i_op       (pop_data),
        .o_out      (o_out)
    );

endmodule

`default_nettype wire

// ===== rtl/brcr_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// brcr_front
// Accepts instruction transactions, splits the word into its fields and
// precomputes the address arithmetic that needs no architectural state.
// ----------------------------------------------------------------------------
module brcr_front (
    brcr_in_if.sink            i_in,
    input  wire logic          i_push_ready,
    output logic               o_push_valid,
    output brcr_pkg::t_op      o_push_data
);
    import brcr_pkg::*;

    logic [WORD_W-1:0] disp;
    logic [WORD_W-1:0] iw;
    t_cmd              cmd;

    assign iw  = i_in.instr_word;
    assign cmd = t_cmd'(i_in.command);

    assign i_in.ready   = i_push_ready;
    assign o_push_valid = i_in.valid;

    // Sign-extended displacement: LI for b, BD for everything else
    always_comb begin
        if (cmd == CMD_B) begin
            disp = {{6{iw[25]}}, iw[25:2], 2'b00};
        end else begin
            disp = {{16{iw[15]}}, iw[15:2], 2'b00};
        end
    end

    always_comb begin
        o_push_data.cmd       = cmd;
        o_push_data.bo        = iw[25:21];
        o_push_data.bi        = iw[20:16];
        o_push_data.lk        = iw[0];
        o_push_data.crf_d     = iw[25:23];
        o_push_data.crf_s     = iw[20:18];
        o_push_data.seq_addr  = i_in.instr_address + WORD_W'(4);
        o_push_data.br_target = iw[1] ? disp : i_in.instr_address + disp;
        o_push_data.operand   = i_in.reg_value;
        // FXM bit 7 selects CR field 0 (bits 31..28)
        for (int i = 0; i < 8; i++) begin
            o_push_data.crm_mask[4*i +: 4] = {4{iw[12 + i]}};
        end
    end

endmodule

`default_nettype wire

// ===== rtl/brcr_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// brcr_queue
// Small FIFO of classified operations between front and back.
// ----------------------------------------------------------------------------
module brcr_queue #(
    parameter int DEPTH = brcr_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push_valid,
    output logic                o_push_ready,
    input  wire brcr_pkg::t_op  i_push_data,
    output logic                o_pop_valid,
    input  wire logic           i_pop_ready,
    output brcr_pkg::t_op       o_pop_data
);
    import brcr_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_op              r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count,  n_count;
    logic             push, pop;

    assign o_push_ready = (r_count != CNT_W'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_data   = r_mem[r_rd_ptr];

    assign push = i_push_valid && o_push_ready;
    assign pop  = o_pop_valid && i_pop_ready;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (push && !pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (pop && !push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/brcr_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// brcr_back
// Executes classified operations against CR, CTR, LR and the XER nibble and
// holds each result in an output register until it is taken.
// ----------------------------------------------------------------------------
module brcr_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_op_valid,
    output logic                o_op_ready,
    input  wire brcr_pkg::t_op  i_op,
    brcr_out_if.source          o_out
);
    import brcr_pkg::*;

    logic [WORD_W-1:0] r_cr,  n_cr;
    logic [WORD_W-1:0] r_ctr, n_ctr;
    logic [WORD_W-1:0] r_lr,  n_lr;
    logic [3:0]        r_xer, n_xer;

    logic              r_out_valid;
    logic [WORD_W-1:0] r_next_address, n_next_address;
    logic              r_taken, n_taken;
    logic [WORD_W-1:0] r_reg_result, n_reg_result;
    logic              r_reg_write, n_reg_write;

    logic              fire;
    logic [WORD_W-1:0] ctr_dec;
    logic              ctr_pass;
    logic              cond_pass;
    logic [4:0]        fld_d_lsb;
    logic [4:0]        fld_s_lsb;

    assign o_op_ready = !r_out_valid || o_out.ready;
    assign fire       = i_op_valid && o_op_ready;

    // CR bit BI sits at 31-BI; field f occupies bits 4*(7-f) upward
    assign ctr_dec   = r_ctr - WORD_W'(1);
    assign ctr_pass  = i_op.bo[2] || ((ctr_dec != '0) != i_op.bo[1]);
    assign cond_pass = i_op.bo[4] || (r_cr[~i_op.bi] == i_op.bo[3]);
    assign fld_d_lsb = {~i_op.crf_d, 2'b00};
    assign fld_s_lsb = {~i_op.crf_s, 2'b00};

    always_comb begin
        n_cr           = r_cr;
        n_ctr          = r_ctr;
        n_lr           = r_lr;
        n_xer          = r_xer;
        n_next_address = i_op.seq_addr;
        n_taken        = 1'b0;
        n_reg_result   = '0;
        n_reg_write    = 1'b0;
        unique case (i_op.cmd)
            CMD_B: begin
                n_next_address = i_op.br_target;
                n_taken        = 1'b1;
                if (i_op.lk) begin
                    n_lr = i_op.seq_addr;
                end
            end
            CMD_BC: begin
                if (!i_op.bo[2]) begin
                    n_ctr = ctr_dec;
                end
                if (ctr_pass && cond_pass) begin
                    n_next_address = i_op.br_target;
                    n_taken        = 1'b1;
                end
                if (i_op.lk) begin
                    n_lr = i_op.seq_addr;
                end
            end
            CMD_BCLR: begin
                if (!i_op.bo[2]) begin
                    n_ctr = ctr_dec;
                end
                if (ctr_pass && cond_pass) begin
                    n_next_address = r_lr & TARGET_MASK;
                    n_taken        = 1'b1;
                end
                if (i_op.lk) begin
                    n_lr = i_op.seq_addr;
                end
            end
            CMD_BCCTR: begin
                if (cond_pass) begin
                    n_next_address = r_ctr & TARGET_MASK;
                    n_taken        = 1'b1;
                end
                if (i_op.lk) begin
                    n_lr = i_op.seq_addr;
                end
            end
            CMD_MCRF: begin
                n_cr[fld_d_lsb +: 4] = r_cr[fld_s_lsb +: 4];
            end
            CMD_MFCR: begin
                n_reg_result = r_cr;
                n_reg_write  = 1'b1;
            end
            CMD_MTCRF: begin
                n_cr = (r_cr & ~i_op.crm_mask) | (i_op.operand & i_op.crm_mask);
            end
            CMD_MCRXR: begin
                n_cr[fld_d_lsb +: 4] = r_xer;
                n_xer                = '0;
            end
            CMD_LOAD_CTR: begin
                n_ctr = i_op.operand;
            end
            CMD_LOAD_LR: begin
                n_lr = i_op.operand;
            end
            CMD_LOAD_XER: begin
                n_xer = 4'((i_op.operand & XER_NIBBLE_MASK) >> XER_NIBBLE_LSB);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cr        <= '0;
            r_ctr       <= '0;
            r_lr        <= '0;
            r_xer       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (fire) begin
                r_cr  <= n_cr;
                r_ctr <= n_ctr;
                r_lr  <= n_lr;
                r_xer <= n_xer;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_next_address <= n_next_address;
            r_taken        <= n_taken;
            r_reg_result   <= n_reg_result;
            r_reg_write    <= n_reg_write;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.next_address = r_next_address;
    assign o_out.taken        = r_taken;
    assign o_out.reg_result   = r_reg_result;
    assign o_out.reg_write    = r_reg_write;

endmodule

`default_nettype wire

// ===== verif/brcr_flow_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// brcr_flow_checker
// Watches the instruction and result channels of the branch unit. It keeps
// its own CR/CTR/LR/XER copy, predicts each result, and compares in order.
// ----------------------------------------------------------------------------
module brcr_flow_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    brcr_in_if   i_in,
    brcr_out_if  i_res,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_checked,
    output int   o_taken
);
    import brcr_pkg::*;

    typedef struct packed {
        logic [WORD_W-1:0] next_address;
        logic              taken;
        logic [WORD_W-1:0] reg_result;
        logic              reg_write;
    } t_flow_result;

    // Predicted architectural state
    logic [WORD_W-1:0] cr_q;
    logic [WORD_W-1:0] ctr_q;
    logic [WORD_W-1:0] lr_q;
    logic [3:0]        xer_q;

    t_flow_result expected_flow_q[$];

    task automatic resolve_instruction(
        input  logic [CMD_W-1:0]  cmd,
        input  logic [WORD_W-1:0] iw,
        input  logic [WORD_W-1:0] addr,
        input  logic [WORD_W-1:0] rv,
        output t_flow_result      res
    );
        logic [4:0]        bo;
        logic [4:0]        bi;
        logic [2:0]        fld_d;
        logic [2:0]        fld_s;
        logic [WORD_W-1:0] disp;
        logic [WORD_W-1:0] seq;
        logic [WORD_W-1:0] mask;
        logic              cond_ok;
        logic              count_ok;
        logic              is_branch;
        bo    = iw[25:21];
        bi    = iw[20:16];
        fld_d = iw[25:23];
        fld_s = iw[20:18];
        seq   = addr + 32'd4;
        mask  = '0;
        disp  = '0;
        res   = '{next_address: seq, taken: 1'b0, reg_result: '0, reg_write: 1'b0};
        is_branch = (cmd == CMD_B) || (cmd == CMD_BC) || (cmd == CMD_BCLR) ||
                    (cmd == CMD_BCCTR);
        cond_ok = bo[4] || (cr_q[31 - int'(bi)] == bo[3]);
        // CTR is decremented and tested by bc and bclr only, never by bcctr
        if ((cmd == CMD_BC || cmd == CMD_BCLR) && !bo[2]) begin
            ctr_q    = ctr_q - 32'd1;
            count_ok = (ctr_q != '0) != bo[1];
        end else begin
            count_ok = 1'b1;
        end
        case (cmd)
            CMD_B: begin
                disp = {{6{iw[25]}}, iw[25:2], 2'b00};
                res.next_address = iw[1] ? disp : addr + disp;
                res.taken        = 1'b1;
            end
            CMD_BC: begin
                disp = {{16{iw[15]}}, iw[15:2], 2'b00};
                if (count_ok && cond_ok) begin
                    res.next_address = iw[1] ? disp : addr + disp;
                    res.taken        = 1'b1;
                end
            end
            CMD_BCLR: begin
                // target uses LR from before this instruction's link write
                if (count_ok && cond_ok) begin
                    res.next_address = lr_q & TARGET_MASK;
                    res.taken        = 1'b1;
                end
            end
            CMD_BCCTR: begin
                if (cond_ok) begin
                    res.next_address = ctr_q & TARGET_MASK;
                    res.taken        = 1'b1;
                end
            end
            CMD_MCRF: begin
                cr_q[31 - 4*int'(fld_d) -: 4] = cr_q[31 - 4*int'(fld_s) -: 4];
            end
            CMD_MFCR: begin
                res.reg_result = cr_q;
                res.reg_write  = 1'b1;
            end
            CMD_MTCRF: begin
                for (int i = 0; i < 8; i++) begin
                    if (iw[19 - i]) begin
                        mask[31 - 4*i -: 4] = 4'hf;
                    end
                end
                cr_q = (cr_q & ~mask) | (rv & mask);
            end
            CMD_MCRXR: begin
                cr_q[31 - 4*int'(fld_d) -: 4] = xer_q;
                xer_q = '0;
            end
            CMD_LOAD_CTR: ctr_q = rv;
            CMD_LOAD_LR:  lr_q  = rv;
            CMD_LOAD_XER: xer_q = rv[XER_NIBBLE_LSB +: 4];
            default: ;
        endcase
        if (is_branch && iw[0]) begin
            lr_q = seq;
        end
    endtask

    always @(posedge i_clk) begin
        t_flow_result exp_r;
        t_flow_result got_r;
        if (!i_rst_n) begin
            cr_q  = '0;
            ctr_q = '0;
            lr_q  = '0;
            xer_q = '0;
            expected_flow_q.delete();
            o_fail_count <= 0;
            o_pending    <= 0;
            o_checked    <= 0;
            o_taken      <= 0;
        end else begin
            if (i_in.valid && i_in.ready) begin
                resolve_instruction(i_in.command, i_in.instr_word, i_in.instr_address,
                                    i_in.reg_value, exp_r);
                expected_flow_q.push_back(exp_r);
            end
            if (i_res.valid && i_res.ready) begin
                got_r = '{next_address: i_res.next_address, taken: i_res.taken,
                          reg_result: i_res.reg_result, reg_write: i_res.reg_write};
                if (expected_flow_q.size() == 0) begin
                    $error("unexpected result transaction, next_address %h", got_r.next_address);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_r = expected_flow_q.pop_front();
                    if (got_r.next_address !== exp_r.next_address) begin
                        $error("next_address: expected %h, got %h",
                               exp_r.next_address, got_r.next_address);
                    end
                    if (got_r.taken !== exp_r.taken) begin
                        $error("taken: expected %b, got %b", exp_r.taken, got_r.taken);
                    end
                    if (got_r.reg_result !== exp_r.reg_result) begin
                        $error("reg_result: expected %h, got %h",
                               exp_r.reg_result, got_r.reg_result);
                    end
                    if (got_r.reg_write !== exp_r.reg_write) begin
                        $error("reg_write: expected %b, got %b",
                               exp_r.reg_write, got_r.reg_write);
                    end
                    if (got_r !== exp_r) begin
                        o_fail_count <= o_fail_count + 1;
                    end
                    o_checked <= o_checked + 1;
                    if (exp_r.taken) begin
                        o_taken <= o_taken + 1;
                    end
                end
            end
            o_pending <= expected_flow_q.size();
        end
    end

endmodule

// ===== verif/branch_and_condition_register_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// branch_and_condition_register_unit_tb
// Drives instruction transactions into the branch unit: a directed opening
// over field extremes and every command, then constrained-by-hand random
// traffic with idle gaps and receiver stalls. The checker predicts results.
// ----------------------------------------------------------------------------
module branch_and_condition_register_unit_tb;
    import brcr_pkg::*;

    localparam int          LATENCY      = 2;       // accept edge to result edge
    localparam int          RANDOM_ITEMS = 930;
    localparam int          LONG_HOLD    = 80;      // receiver hold, cycles
    localparam int          CYCLE_LIMIT  = 400_000;
    localparam logic [CMD_W-1:0] CMD_UNUSED_LO = 4'd11;  // first unassigned code
    localparam logic [CMD_W-1:0] CMD_UNUSED_HI = 4'd15;
    localparam logic [WORD_W-1:0] BASE_ADDR    = 32'h0000_1000;

    logic clk = 1'b0;
    logic rst_n;

    // Traffic shaping: mode 0 = no idling, mode 1 = random gaps
    int   src_mode;
    int   sink_mode;
    logic long_hold_req;
    int   txn_sent;
    int   cycle_cnt = 0;

    int fail_count;
    int pending;
    int checked;
    int taken_cnt;

    brcr_in_if  in_ch ();
    brcr_out_if out_ch ();

    branch_and_condition_register_unit u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    brcr_flow_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in         (in_ch),
        .i_res        (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_taken      (taken_cnt)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog: a hung handshake or a missing result ends here
    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // BO/BI/BD form of a conditional branch word; primary opcode bits are don't-care
    function automatic logic [WORD_W-1:0] bform(
        input logic [4:0]  bo,
        input logic [4:0]  bi,
        input logic [15:0] bd,
        input logic        aa,
        input logic        lk
    );
        return {6'd16, bo, bi, bd[15:2], aa, lk};
    endfunction

    // One transaction: optional idle gap, then hold valid until ready is seen.
    // valid is left high on return so back-to-back items keep it asserted.
    task automatic send_txn(
        input logic [CMD_W-1:0]  cmd,
        input logic [WORD_W-1:0] iw,
        input logic [WORD_W-1:0] addr,
        input logic [WORD_W-1:0] rv
    );
        int gap;
        int r;
        r   = $urandom_range(0, 99);
        gap = 0;
        if (src_mode != 0) begin
            if (r >= 92) begin
                gap = $urandom_range(8, 30);
            end else if (r >= 70) begin
                gap = $urandom_range(1, 3);
            end
        end
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.command       <= cmd;
        in_ch.instr_word    <= iw;
        in_ch.instr_address <= addr;
        in_ch.reg_value     <= rv;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        txn_sent++;
    endtask

    // Result-side ready: random stalls, bursts of always-ready, and one long
    // hold on request so the queue fills and backpressure reaches the input.
    initial begin
        int len;
        int r;
        out_ch.ready <= 1'b0;
        @(posedge clk);
        forever begin
            r = $urandom_range(0, 99);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                out_ch.ready <= 1'b0;
                len = LONG_HOLD;
            end else if (sink_mode == 0) begin
                out_ch.ready <= 1'b1;
                len = 1;
            end else if (r < 65) begin
                out_ch.ready <= 1'b1;
                len = $urandom_range(1, 4);
            end else if (r < 93) begin
                out_ch.ready <= 1'b0;
                len = $urandom_range(1, 3);
            end else begin
                out_ch.ready <= 1'b0;
                len = $urandom_range(10, 30);
            end
            repeat (len) @(posedge clk);
        end
    end

    initial begin
        int                n;
        int                r;
        int                directed_cnt;
        logic [CMD_W-1:0]  cmd;
        logic [WORD_W-1:0] iw;
        logic [WORD_W-1:0] addr;
        logic [WORD_W-1:0] rv;

        src_mode      = 1;
        sink_mode     = 1;
        long_hold_req = 1'b0;
        txn_sent      = 0;
        rst_n               <= 1'b0;
        in_ch.valid         <= 1'b0;
        in_ch.command       <= '0;
        in_ch.instr_word    <= '0;
        in_ch.instr_address <= '0;
        in_ch.reg_value     <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // ---- Directed opening ----
        // Register loads, including the full XER nibble
        send_txn(CMD_LOAD_CTR, '0, BASE_ADDR, 32'd3);
        send_txn(CMD_LOAD_LR,  '0, BASE_ADDR, 32'hffff_ffff);
        send_txn(CMD_LOAD_XER, '0, BASE_ADDR, 32'hf000_0000);
        // mtcrf with every field selected, then read back
        send_txn(CMD_MTCRF, 32'h000f_f000, BASE_ADDR, 32'ha5a5_5a5a);
        send_txn(CMD_MFCR,  '0, BASE_ADDR, '0);
        // mcrxr into the last field, then again: XER must read back cleared
        send_txn(CMD_MCRXR, 32'h0380_0000, BASE_ADDR, '0);
        send_txn(CMD_MCRXR, 32'h0000_0000, BASE_ADDR, '0);
        // mcrf field 7 into field 3
        send_txn(CMD_MCRF, 32'h019c_0000, BASE_ADDR, '0);
        send_txn(CMD_MFCR, '0, BASE_ADDR, '0);
        // b: most negative absolute LI with link, and max positive relative
        // LI from the top of the address space (wraps)
        send_txn(CMD_B, 32'hfe00_0003, 32'hffff_fffc, '0);
        send_txn(CMD_B, 32'h01ff_fffc, 32'hffff_fffc, '0);
        // bc with CTR decrement and CR test
        send_txn(CMD_BC, bform(5'b00000, 5'd1, 16'h0010, 1'b0, 1'b0), BASE_ADDR, '0);
        // bc absolute with negative BD, condition ignored
        send_txn(CMD_BC, bform(5'b10100, 5'd0, 16'h8000, 1'b1, 1'b0), BASE_ADDR, '0);
        // bc branch-if-CTR-zero with link: LR updates even when not taken
        send_txn(CMD_BC, bform(5'b10010, 5'd0, 16'h7ffc, 1'b0, 1'b1), BASE_ADDR, '0);
        // bclr with link: target from the old LR
        send_txn(CMD_BCLR, bform(5'b10100, 5'd0, 16'h0000, 1'b0, 1'b1), 32'h0000_2000, '0);
        // bcctr with a decrementing BO: CTR must stay untouched
        send_txn(CMD_BCCTR, bform(5'b00000, 5'd31, 16'h0000, 1'b0, 1'b1), BASE_ADDR, '0);
        // CTR wrap from zero on decrement
        send_txn(CMD_LOAD_CTR, '0, BASE_ADDR, 32'd0);
        send_txn(CMD_BC, bform(5'b10000, 5'd0, 16'h0040, 1'b0, 1'b0), BASE_ADDR, '0);
        send_txn(CMD_BCCTR, bform(5'b10100, 5'd0, 16'h0000, 1'b0, 1'b0), BASE_ADDR, '0);
        // Unassigned command codes fall through
        send_txn(CMD_UNUSED_LO, 32'hffff_ffff, BASE_ADDR, 32'hffff_ffff);
        send_txn(CMD_UNUSED_HI, 32'hffff_ffff, BASE_ADDR, 32'hffff_ffff);
        // mtcrf with an empty mask; unaligned address on mfcr
        send_txn(CMD_MTCRF, 32'h0000_0000, BASE_ADDR, 32'hffff_ffff);
        send_txn(CMD_MFCR, '0, 32'h1234_5677, '0);
        // load xer ignores the low 28 bits
        send_txn(CMD_LOAD_XER, '0, BASE_ADDR, 32'h0fff_ffff);
        send_txn(CMD_MCRXR, 32'h0000_0000, BASE_ADDR, '0);
        directed_cnt = txn_sent;

        // ---- Random traffic ----
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 100 == 0) begin
                src_mode  = $urandom_range(0, 1);
                sink_mode = $urandom_range(0, 1);
            end
            if (n == 300) begin
                // Receiver holds off while items keep coming back to back
                long_hold_req = 1'b1;
                src_mode      = 0;
            end
            if (n == 600) begin
                // Sender pauses until every outstanding result is back
                in_ch.valid <= 1'b0;
                @(posedge clk);
                while (pending != 0) @(posedge clk);
            end
            r    = $urandom_range(0, 99);
            iw   = $urandom;
            rv   = $urandom;
            addr = $urandom;
            if ($urandom_range(0, 9) != 0) begin
                addr = addr & TARGET_MASK;
            end
            // Weighted toward conditional branches; small CTR loads so the
            // decrement reaches zero often
            if      (r < 10) cmd = CMD_B;
            else if (r < 35) cmd = CMD_BC;
            else if (r < 45) cmd = CMD_BCLR;
            else if (r < 55) cmd = CMD_BCCTR;
            else if (r < 62) cmd = CMD_MCRF;
            else if (r < 70) cmd = CMD_MFCR;
            else if (r < 78) cmd = CMD_MTCRF;
            else if (r < 83) cmd = CMD_MCRXR;
            else if (r < 88) cmd = CMD_LOAD_CTR;
            else if (r < 92) cmd = CMD_LOAD_LR;
            else if (r < 96) cmd = CMD_LOAD_XER;
            else             cmd = CMD_UNUSED_LO + CMD_W'($urandom_range(0, 4));
            if (cmd == CMD_LOAD_CTR && $urandom_range(0, 1) != 0) begin
                rv = $urandom_range(0, 4);
            end
            send_txn(cmd, iw, addr, rv);
        end

        // ---- Drain ----
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (LATENCY + 8) @(posedge clk);

        $display("Run covered %0d transactions (%0d directed, %0d random) over all commands",
                 txn_sent, directed_cnt, txn_sent - directed_cnt);
        $display("%0d results compared, %0d redirected flow; long receiver hold and full drain",
                 checked, taken_cnt);
        if (fail_count == 0 && pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/brcr_pkg.sv
rtl/brcr_in_if.sv
rtl/brcr_out_if.sv
rtl/brcr_front.sv
rtl/brcr_queue.sv
rtl/brcr_back.sv
rtl/branch_and_condition_register_unit.sv
verif/brcr_flow_checker.sv
verif/branch_and_condition_register_unit_tb.sv
